FILE: src/delimited_frame_receiver_crc32_unit_assert.svh
// Assertion macros for the frame receiver.
// Used by the top level; expects clk and rst in scope.
`ifndef DELIMITED_FRAME_RECEIVER_CRC32_UNIT_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_CRC32_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dfr_pkg.sv
// Shared types, codes and the CRC-32 byte update for the frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package dfr_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Event codes
  localparam logic [2:0] EV_DATA    = 3'd0;
  localparam logic [2:0] EV_GOOD    = 3'd1;
  localparam logic [2:0] EV_TOOBIG  = 3'd2;
  localparam logic [2:0] EV_BADEND  = 3'd3;
  localparam logic [2:0] EV_BADCRC  = 3'd4;
  localparam logic [2:0] EV_TIMEOUT = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_START_DELIM = 2'd0;
  localparam logic [1:0] REG_END_DELIM   = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;
  localparam logic [1:0] REG_GAP_LIMIT   = 2'd3;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  data_byte;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_len;
  } evt_t;

  typedef struct packed {
    logic [7:0]  start_delimiter;
    logic [7:0]  end_delimiter;
    logic [15:0] max_payload_len;
    logic [15:0] byte_gap_limit;
  } cfg_t;

  typedef struct packed {
    logic emit;
    logic hunting;
    evt_t evt;
  } res_t;

  // Reflected CRC-32 update over one byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: src/dfr_stream_if.sv
// Valid/ready stream channel with a typed payload.
// Payload types come from dfr_pkg.
`timescale 1ns / 1ps

interface dfr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/dfr_frame_fsm.sv
// Frame parser state: phase, header holds, CRC accumulator and gap timer.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_frame_fsm (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  dfr_pkg::req_t beat,
  input  dfr_pkg::cfg_t cfg,
  output dfr_pkg::res_t res
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_CMD     = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_CRC     = 3'd5;
  localparam logic [2:0] PH_END     = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [7:0]  cmd_hold, cmd_hold_next;
  logic [15:0] len_hold, len_hold_next;
  logic [15:0] payload_count, payload_count_next;
  logic [31:0] crc_accum, crc_accum_next;
  logic [31:0] rx_crc_hold, rx_crc_hold_next;
  logic [1:0]  crc_byte_idx, crc_byte_idx_next;
  logic [15:0] gap_ticks, gap_ticks_next;

  logic [31:0] crc_upd;
  logic [15:0] gap_inc;
  logic [15:0] count_inc;
  logic [15:0] len_full;
  logic        emit;
  logic [2:0]  kind;
  logic [7:0]  data;

  assign crc_upd   = dfr_pkg::crc32_byte(crc_accum, beat.rx_byte);
  assign gap_inc   = (gap_ticks == 16'hFFFF) ? gap_ticks : gap_ticks + 16'd1;
  assign count_inc = payload_count + 16'd1;
  assign len_full  = {beat.rx_byte, len_hold[7:0]};

  always_comb begin
    phase_next         = phase;
    cmd_hold_next      = cmd_hold;
    len_hold_next      = len_hold;
    payload_count_next = payload_count;
    crc_accum_next     = crc_accum;
    rx_crc_hold_next   = rx_crc_hold;
    crc_byte_idx_next  = crc_byte_idx;
    gap_ticks_next     = gap_ticks;
    emit               = 1'b0;
    kind               = dfr_pkg::EV_DATA;
    data               = 8'h00;

    if (beat.req_type) begin
      // Tick: only counts inside a frame
      if (phase != PH_HUNT && phase <= PH_END) begin
        gap_ticks_next = gap_inc;
        if (gap_inc >= cfg.byte_gap_limit) begin
          phase_next = PH_HUNT;
          emit       = 1'b1;
          kind       = dfr_pkg::EV_TIMEOUT;
        end
      end
    end else begin
      gap_ticks_next = 16'h0000;
      case (phase)
        PH_CMD: begin
          cmd_hold_next  = beat.rx_byte;
          crc_accum_next = crc_upd;
          phase_next     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_hold_next  = {8'h00, beat.rx_byte};
          crc_accum_next = crc_upd;
          phase_next     = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hold_next  = len_full;
          crc_accum_next = crc_upd;
          if (len_full > cfg.max_payload_len) begin
            phase_next = PH_HUNT;
            emit       = 1'b1;
            kind       = dfr_pkg::EV_TOOBIG;
          end else begin
            phase_next = (len_full == 16'h0000) ? PH_CRC : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_accum_next     = crc_upd;
          payload_count_next = count_inc;
          if (count_inc >= len_hold) phase_next = PH_CRC;
          emit = 1'b1;
          kind = dfr_pkg::EV_DATA;
          data = beat.rx_byte;
        end
        PH_CRC: begin
          unique case (crc_byte_idx)
            2'd0: rx_crc_hold_next = rx_crc_hold | {24'h000000, beat.rx_byte};
            2'd1: rx_crc_hold_next = rx_crc_hold | {16'h0000, beat.rx_byte, 8'h00};
            2'd2: rx_crc_hold_next = rx_crc_hold | {8'h00, beat.rx_byte, 16'h0000};
            2'd3: rx_crc_hold_next = rx_crc_hold | {beat.rx_byte, 24'h000000};
          endcase
          crc_byte_idx_next = crc_byte_idx + 2'd1;
          if (crc_byte_idx == 2'd3) phase_next = PH_END;
        end
        PH_END: begin
          phase_next = PH_HUNT;
          emit       = 1'b1;
          if (beat.rx_byte != cfg.end_delimiter) begin
            kind = dfr_pkg::EV_BADEND;
          end else if ((crc_accum ^ dfr_pkg::CRC_INIT) != rx_crc_hold) begin
            kind = dfr_pkg::EV_BADCRC;
          end else begin
            kind = dfr_pkg::EV_GOOD;
          end
        end
        default: begin
          // Hunting, and unused codes behave as hunting
          phase_next = PH_HUNT;
          if (beat.rx_byte == cfg.start_delimiter) begin
            phase_next         = PH_CMD;
            cmd_hold_next      = 8'h00;
            len_hold_next      = 16'h0000;
            payload_count_next = 16'h0000;
            crc_accum_next     = dfr_pkg::CRC_INIT;
            rx_crc_hold_next   = 32'h00000000;
            crc_byte_idx_next  = 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      cmd_hold      <= 8'h00;
      len_hold      <= 16'h0000;
      payload_count <= 16'h0000;
      crc_accum     <= dfr_pkg::CRC_INIT;
      rx_crc_hold   <= 32'h00000000;
      crc_byte_idx  <= 2'd0;
      gap_ticks     <= 16'h0000;
    end else if (step) begin
      phase         <= phase_next;
      cmd_hold      <= cmd_hold_next;
      len_hold      <= len_hold_next;
      payload_count <= payload_count_next;
      crc_accum     <= crc_accum_next;
      rx_crc_hold   <= rx_crc_hold_next;
      crc_byte_idx  <= crc_byte_idx_next;
      gap_ticks     <= gap_ticks_next;
    end
  end

  always_comb begin
    res                = '0;
    res.emit           = emit;
    res.hunting        = (phase == PH_HUNT);
    res.evt.event_kind = kind;
    res.evt.data_byte  = data;
    res.evt.frame_cmd  = cmd_hold_next;
    res.evt.frame_len  = len_hold_next;
  end

endmodule

FILE: src/delimited_frame_receiver_crc32_unit.sv
// Delimited frame receiver with CRC-32 check: one beat per cycle, sustained
// while events are taken. Each beat (a received byte or a millisecond tick)
// lands in an input register, passes through the frame parser and CRC-32 byte
// update, and any event lands in the result register, which drives event
// valid. The byte-wide CRC update between those two registers sets the clock.
// While a finished event waits downstream, one more beat can enter the input
// register; after that, input stalls until the event is taken.
// Depends on dfr_pkg, dfr_stream_if, dfr_frame_fsm and the assertion header.
`timescale 1ns / 1ps

`include "delimited_frame_receiver_crc32_unit_assert.svh"

module delimited_frame_receiver_crc32_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  dfr_stream_if.sink   req,
  dfr_stream_if.source evt
);

  dfr_pkg::cfg_t cfg;
  dfr_pkg::req_t s1_beat;
  dfr_pkg::res_t res;
  logic          s1_valid;
  logic          step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delimiter <= 8'd0;
      cfg.end_delimiter   <= 8'd0;
      cfg.max_payload_len <= 16'd256;
      cfg.byte_gap_limit  <= 16'd300;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        dfr_pkg::REG_START_DELIM: cfg.start_delimiter <= cfg_wdata[7:0];
        dfr_pkg::REG_END_DELIM:   cfg.end_delimiter   <= cfg_wdata[7:0];
        dfr_pkg::REG_MAX_LEN:     cfg.max_payload_len <= cfg_wdata;
        dfr_pkg::REG_GAP_LIMIT:   cfg.byte_gap_limit  <= cfg_wdata;
      endcase
    end
  end

  // Advance the held beat when the result register is free or draining
  assign step      = s1_valid && (!evt.valid || evt.ready);
  assign req.ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) s1_beat <= req.payload;
  end

  dfr_frame_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .beat (s1_beat),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (step && res.emit) begin
      evt.valid <= 1'b1;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) evt.payload <= res.evt;
  end

  `DFR_ASSERT_IMPL(a_data_from_byte,
    step && res.emit && res.evt.event_kind == dfr_pkg::EV_DATA,
    !s1_beat.req_type, "payload event raised by a tick")
  `DFR_ASSERT_IMPL(a_timeout_from_tick,
    step && res.emit && res.evt.event_kind == dfr_pkg::EV_TIMEOUT,
    s1_beat.req_type, "timeout raised by a byte")
  `DFR_ASSERT_NEXT(a_verdict_hunts,
    step && res.emit && res.evt.event_kind != dfr_pkg::EV_DATA,
    res.hunting, "parser not hunting after a verdict")
  `DFR_ASSERT_IMPL(a_kind_range, evt.valid,
    evt.payload.event_kind <= dfr_pkg::EV_TIMEOUT, "event code out of range")

endmodule
